// ===== src/mrf_pkg.sv =====
// ----------------------------------------------------------------------------
// mrf_pkg
// Shared types, constants and CRC helpers for the Modbus RTU request framer.
// ----------------------------------------------------------------------------
package mrf_pkg;

  localparam int FRAME_LEN  = 8;
  localparam int CRC_SPAN   = 6;
  localparam int IDX_W      = $clog2(FRAME_LEN);
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [7:0]  FC_RESET = 8'h01;

  // byte positions inside the frame
  localparam logic [IDX_W-1:0] BYTE_SLAVE   = 3'd0;
  localparam logic [IDX_W-1:0] BYTE_FUNC    = 3'd1;
  localparam logic [IDX_W-1:0] BYTE_ADDR_HI = 3'd2;
  localparam logic [IDX_W-1:0] BYTE_ADDR_LO = 3'd3;
  localparam logic [IDX_W-1:0] BYTE_QTY_HI  = 3'd4;
  localparam logic [IDX_W-1:0] BYTE_QTY_LO  = 3'd5;
  localparam logic [IDX_W-1:0] BYTE_CRC_LO  = 3'd6;
  localparam logic [IDX_W-1:0] BYTE_CRC_HI  = 3'd7;

  typedef struct packed {
    logic [7:0]  slave_id;
    logic [7:0]  func_code;
    logic [15:0] start_address;
    logic [15:0] quantity;
    logic [15:0] crc;
  } frame_t;

  // fold one byte into a reflected CRC-16
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  // byte of the frame in transmit order
  function automatic logic [7:0] byte_sel(input frame_t f, input logic [IDX_W-1:0] idx);
    logic [7:0] r;
    unique case (idx)
      BYTE_SLAVE:   r = f.slave_id;
      BYTE_FUNC:    r = f.func_code;
      BYTE_ADDR_HI: r = f.start_address[15:8];
      BYTE_ADDR_LO: r = f.start_address[7:0];
      BYTE_QTY_HI:  r = f.quantity[15:8];
      BYTE_QTY_LO:  r = f.quantity[7:0];
      BYTE_CRC_LO:  r = f.crc[7:0];
      BYTE_CRC_HI:  r = f.crc[15:8];
      default:      r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

// ===== src/mrf_crc_pipe.sv =====
// ----------------------------------------------------------------------------
// mrf_crc_pipe
// Six-stage CRC pipeline: each stage folds one header byte into the CRC.
// ----------------------------------------------------------------------------
module mrf_crc_pipe (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  mrf_pkg::frame_t in_frame,
  output logic            out_valid,
  input  logic            out_ready,
  output mrf_pkg::frame_t out_frame
);

  localparam int N  = mrf_pkg::CRC_SPAN;
  localparam int IW = mrf_pkg::IDX_W;

  mrf_pkg::frame_t st       [N];
  mrf_pkg::frame_t st_next  [N];
  logic [N-1:0]    vld;
  logic [N-1:0]    vld_next;
  logic [N-1:0]    ld;

  // a stage loads when empty or when its content moves on
  always_comb begin
    ld[N-1] = !vld[N-1] || out_ready;
    for (int i = N - 2; i >= 0; i--) begin
      ld[i] = !vld[i] || ld[i+1];
    end
  end

  // stage 0 folds the slave address into the seed, stage i folds header byte i
  always_comb begin
    vld_next[0]    = ld[0] ? in_valid : vld[0];
    st_next[0]     = in_frame;
    st_next[0].crc = mrf_pkg::crc_byte(mrf_pkg::CRC_INIT, in_frame.slave_id);
    for (int i = 1; i < N; i++) begin
      vld_next[i]    = ld[i] ? vld[i-1] : vld[i];
      st_next[i]     = st[i-1];
      st_next[i].crc = mrf_pkg::crc_byte(st[i-1].crc,
                         mrf_pkg::byte_sel(st[i-1], IW'(i)));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= vld_next;
    end
    for (int i = 0; i < N; i++) begin
      if (ld[i]) begin
        st[i] <= st_next[i];
      end
    end
  end

  assign in_ready  = ld[0];
  assign out_valid = vld[N-1];
  assign out_frame = st[N-1];

endmodule

// ===== src/mrf_serializer.sv =====
// ----------------------------------------------------------------------------
// mrf_serializer
// Holds one finished frame and sends its eight bytes, one per transaction.
// ----------------------------------------------------------------------------
module mrf_serializer (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  mrf_pkg::frame_t           in_frame,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [7:0]                out_byte,
  output logic                      out_last
);

  mrf_pkg::frame_t           frame;
  logic                      busy;
  logic [mrf_pkg::IDX_W-1:0] cnt;
  logic                      last;
  logic                      take;

  assign last     = (cnt == mrf_pkg::BYTE_CRC_HI);
  // take the next frame when idle or while the last byte leaves
  assign in_ready = !busy || (last && out_ready);
  assign take     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= mrf_pkg::BYTE_SLAVE;
    end else if (take) begin
      busy <= 1'b1;
      cnt  <= mrf_pkg::BYTE_SLAVE;
    end else if (busy && out_ready) begin
      if (last) begin
        busy <= 1'b0;
        cnt  <= mrf_pkg::BYTE_SLAVE;
      end else begin
        cnt <= cnt + 1'b1;
      end
    end
    if (take) begin
      frame <= in_frame;
    end
  end

  assign out_valid = busy;
  assign out_byte  = mrf_pkg::byte_sel(frame, cnt);
  assign out_last  = last;

endmodule

// ===== src/modbus_read_request_framer.sv =====
// ----------------------------------------------------------------------------
// modbus_read_request_framer
// Builds an 8-byte Modbus RTU request frame with CRC-16 for each request.
// ----------------------------------------------------------------------------
//   channel  | direction | contents
//   s_axis   | in        | slave_id, start_address, quantity (one request)
//   m_axis   | out       | frame_byte, last_byte flag as tlast (8 per request)
//   cfg      | in        | function_code write, no read-back
//
// A request passes a six-stage CRC pipeline (one header byte per stage) and
// is then loaded into the output stage, which offers its bytes on m_axis.
// The output stage sends one byte per cycle while m_tready is high and takes
// the next frame as the last byte of the current one leaves. Reset is
// synchronous and clears all valid bits and restores function_code to 1.
// Stalls on m_axis back up through the pipeline without loss.
// ----------------------------------------------------------------------------
module modbus_read_request_framer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // slave_id[7:0], start_address[23:8], quantity[39:24]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // frame_byte[7:0]
  output logic        m_tlast,
  input  logic        cfg_wen,
  input  logic [7:0]  cfg_wdata
);

  logic [7:0]      func_code;
  mrf_pkg::frame_t in_frame;
  mrf_pkg::frame_t crc_frame;
  logic            crc_valid;
  logic            crc_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      func_code <= mrf_pkg::FC_RESET;
    end else if (cfg_wen) begin
      func_code <= cfg_wdata;
    end
  end

  always_comb begin
    in_frame.slave_id      = s_tdata[7:0];
    in_frame.func_code     = func_code;
    in_frame.start_address = s_tdata[23:8];
    in_frame.quantity      = s_tdata[39:24];
    in_frame.crc           = mrf_pkg::CRC_INIT;
  end

  mrf_crc_pipe u_crc (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_frame  (in_frame),
    .out_valid (crc_valid),
    .out_ready (crc_ready),
    .out_frame (crc_frame)
  );

  mrf_serializer u_ser (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (crc_valid),
    .in_ready  (crc_ready),
    .in_frame  (crc_frame),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_byte  (m_tdata),
    .out_last  (m_tlast)
  );

endmodule
